// ----- rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define MTF_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define MTF_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) else $error(msg);

`endif

// ----- rtl/mtf_pkg.sv -----
package mtf_pkg;

    localparam int KEY_W = 32;
    localparam int PAY_W = 32;
    localparam int CNT_W = 5;
    localparam int RIDX_W = 4;
    localparam int HPOS_W = 4;
    localparam logic [CNT_W-1:0] CAP_RESET = 5'd10;

    typedef enum logic {
        CMD_ACCESS = 1'b0,
        CMD_READ   = 1'b1
    } t_cmd;

    // broadcast from the top to every cell
    typedef struct packed {
        logic             load;
        logic [CNT_W-1:0] last;
        logic [CNT_W-1:0] sel;
        logic [CNT_W-1:0] fill;
        logic [KEY_W-1:0] key;
    } t_cell_ctl;

    // what each cell reports back
    typedef struct packed {
        logic             match;
        logic [CNT_W-1:0] pos;
        logic [KEY_W-1:0] sel_key;
        logic [PAY_W-1:0] sel_payload;
    } t_cell_stat;

    // capacity clamped to 1..depth
    function automatic logic [CNT_W-1:0] eff_cap(input logic [CNT_W-1:0] cap, input int depth);
        logic [CNT_W-1:0] c;
        c = cap;
        if (cap == '0) begin
            c = 5'd1;
        end else if (int'(cap) > depth) begin
            c = CNT_W'(depth);
        end
        return c;
    endfunction

endpackage

// ----- rtl/mtf_cell.sv -----
module mtf_cell
    import mtf_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic             i_clk,
    input  t_cell_ctl        i_ctl,
    input  logic [KEY_W-1:0] i_prev_key,
    input  logic [PAY_W-1:0] i_prev_payload,
    output logic [KEY_W-1:0] o_key,
    output logic [PAY_W-1:0] o_payload,
    output t_cell_stat       o_stat
);

    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_payload;
    logic             w_held;
    logic             w_pick;

    assign w_held = IDX < int'(i_ctl.fill);
    assign w_pick = IDX == int'(i_ctl.sel);

    // take the neighbour's entry when the shift reaches this position
    always_ff @(posedge i_clk) begin
        if (i_ctl.load && (IDX <= int'(i_ctl.last))) begin
            r_key     <= i_prev_key;
            r_payload <= i_prev_payload;
        end
    end

    always_comb begin
        o_stat.match       = w_held && (r_key == i_ctl.key);
        o_stat.pos         = o_stat.match ? CNT_W'(IDX) : '0;
        o_stat.sel_key     = w_pick ? r_key : '0;
        o_stat.sel_payload = w_pick ? r_payload : '0;
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;

endmodule

// ----- rtl/move_to_front_recency_list.sv -----
// bounded move-to-front list built as a row of key/payload cells
// latency: a beat accepted at one edge shows its result at the output the next cycle
// throughput: one beat per cycle while the output is taken; all cells compare and
//   shift in the same cycle, input ready whenever the output register is empty or taken
// reset: synchronous active low, clears the count and the output valid, capacity to 10
`include "assert_macros.svh"

module move_to_front_recency_list
    import mtf_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CNT_W-1:0]  i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_cmd,
    input  logic [KEY_W-1:0]  i_key,
    input  logic [PAY_W-1:0]  i_payload,
    input  logic [RIDX_W-1:0] i_read_index,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic              o_hit,
    output logic [HPOS_W-1:0] o_hit_position,
    output logic              o_evicted,
    output logic [KEY_W-1:0]  o_evicted_key,
    output logic [PAY_W-1:0]  o_evicted_payload,
    output logic              o_entry_valid,
    output logic [KEY_W-1:0]  o_entry_key,
    output logic [PAY_W-1:0]  o_entry_payload,
    output logic [CNT_W-1:0]  o_count
);

    logic [CNT_W-1:0] r_cap;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic             r_valid;
    logic             r_hit, n_hit;
    logic [HPOS_W-1:0] r_hpos, n_hpos;
    logic             r_ev, n_ev;
    logic [KEY_W-1:0] r_evk, n_evk;
    logic [PAY_W-1:0] r_evp, n_evp;
    logic             r_eok, n_eok;
    logic [KEY_W-1:0] r_ek, n_ek;
    logic [PAY_W-1:0] r_ep, n_ep;

    logic             w_accept;
    logic             w_access;
    logic [CNT_W-1:0] w_cap;
    logic             w_full;
    logic             w_any_hit;
    logic [CNT_W-1:0] w_hpos;
    logic [KEY_W-1:0] w_sel_key;
    logic [PAY_W-1:0] w_sel_pay;
    logic [DEPTH-1:0] w_match;
    t_cell_ctl        w_ctl;
    t_cell_stat       w_stat [DEPTH];
    logic [KEY_W-1:0] w_key [DEPTH];
    logic [PAY_W-1:0] w_pay [DEPTH];

    assign o_in_ready = !r_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_access   = t_cmd'(i_cmd) == CMD_ACCESS;
    assign w_cap      = eff_cap(r_cap, DEPTH);
    assign w_full     = r_fill >= w_cap;

    // combine what the cells report
    always_comb begin
        w_hpos    = '0;
        w_sel_key = '0;
        w_sel_pay = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_match[i] = w_stat[i].match;
            w_hpos     = w_hpos | w_stat[i].pos;
            w_sel_key  = w_sel_key | w_stat[i].sel_key;
            w_sel_pay  = w_sel_pay | w_stat[i].sel_payload;
        end
        w_any_hit = |w_match;
    end

    always_comb begin
        w_ctl.load = w_accept && w_access;
        w_ctl.fill = r_fill;
        w_ctl.key  = i_key;
        if (w_any_hit) begin
            w_ctl.last = w_hpos;
        end else if (!w_full) begin
            w_ctl.last = r_fill;
        end else begin
            w_ctl.last = w_cap - 5'd1;
        end
        // one read port: the back entry on an access, the asked-for one on a read
        w_ctl.sel = w_access ? (w_cap - 5'd1) : CNT_W'(i_read_index);
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [KEY_W-1:0] w_pk;
        logic [PAY_W-1:0] w_pp;
        if (g == 0) begin : g_head
            assign w_pk = i_key;
            assign w_pp = i_payload;
        end else begin : g_body
            assign w_pk = w_key[g-1];
            assign w_pp = w_pay[g-1];
        end
        mtf_cell #(.IDX(g)) u_cell (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl),
            .i_prev_key     (w_pk),
            .i_prev_payload (w_pp),
            .o_key          (w_key[g]),
            .o_payload      (w_pay[g]),
            .o_stat         (w_stat[g])
        );
    end

    always_comb begin
        n_hit  = w_access && w_any_hit;
        n_hpos = n_hit ? w_hpos[HPOS_W-1:0] : '0;
        n_ev   = w_access && !w_any_hit && w_full;
        n_evk  = n_ev ? w_sel_key : '0;
        n_evp  = n_ev ? w_sel_pay : '0;
        n_eok  = !w_access && (CNT_W'(i_read_index) < r_fill);
        n_ek   = n_eok ? w_sel_key : '0;
        n_ep   = n_eok ? w_sel_pay : '0;
        n_fill = r_fill;
        if (w_access && !w_any_hit && !w_full) begin
            n_fill = r_fill + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
                // lowering the capacity drops the tail without reporting it
                if (r_fill > eff_cap(i_cfg_data, DEPTH)) begin
                    r_fill <= eff_cap(i_cfg_data, DEPTH);
                end
            end else if (w_accept) begin
                r_fill <= n_fill;
            end
            if (w_accept) begin
                r_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit  <= n_hit;
            r_hpos <= n_hpos;
            r_ev   <= n_ev;
            r_evk  <= n_evk;
            r_evp  <= n_evp;
            r_eok  <= n_eok;
            r_ek   <= n_ek;
            r_ep   <= n_ep;
        end
    end

    assign o_out_valid       = r_valid;
    assign o_hit             = r_hit;
    assign o_hit_position    = r_hpos;
    assign o_evicted         = r_ev;
    assign o_evicted_key     = r_evk;
    assign o_evicted_payload = r_evp;
    assign o_entry_valid     = r_eok;
    assign o_entry_key       = r_ek;
    assign o_entry_payload   = r_ep;
    assign o_count           = r_fill;

    `MTF_ASSERT(a_key_unique, i_clk, i_rst_n, $onehot0(w_match), "key held in more than one cell")
    `MTF_ASSERT(a_fill_bound, i_clk, i_rst_n, r_fill <= w_cap, "count above capacity")
    `MTF_ASSERT(a_evict_full, i_clk, i_rst_n, (r_valid && r_ev) |-> (r_fill == w_cap), "eviction from a list that is not full")
    `MTF_NEVER(a_hit_no_evict, i_clk, i_rst_n, r_valid && r_hit && r_ev, "hit and eviction in one beat")

endmodule
